>>> hdl/vertex_rotate_project_assert.svh
// Assertion macros shared by the vertex rotate/project checkers.
`ifndef VERTEX_ROTATE_PROJECT_ASSERT_SVH
`define VERTEX_ROTATE_PROJECT_ASSERT_SVH

// Check that an expression holds at every clock edge out of reset.
`define VRP_CHECK(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("vrp check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define VRP_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vrp implication failed");

`endif

>>> hdl/vrp_pkg.sv
// Package for the vertex rotate/project block: types, constants, helpers.
package vrp_pkg;

  // Register map indexes
  typedef enum logic [2:0] {
    REG_QUAT_W,
    REG_QUAT_X,
    REG_QUAT_Y,
    REG_QUAT_Z,
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_PIXEL_SCALE
  } vrp_reg_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic        [15:0] pixel_scale;
  } vrp_cfg_t;

  localparam int unsigned VRP_ADDR_W  = 5;
  localparam int unsigned VRP_LATENCY = 11;

  // Reset values
  localparam logic signed [15:0] VRP_QUAT_W_RST = 16'sd16384;
  localparam logic        [15:0] VRP_SCALE_RST  = 16'd256;

  // Camera rows, Q0.16 magnitudes
  localparam logic signed [16:0] VRP_SCR_XX = 17'sd58615;
  localparam logic signed [16:0] VRP_SCR_XY = 17'sd29308;
  localparam logic signed [16:0] VRP_SCR_YX = 17'sd16325;
  localparam logic signed [16:0] VRP_SCR_YY = 17'sd32657;
  localparam logic signed [16:0] VRP_SCR_YZ = 17'sd54428;
  localparam logic signed [16:0] VRP_DEP_X  = 17'sd24340;
  localparam logic signed [16:0] VRP_DEP_Y  = 17'sd48680;
  localparam logic signed [16:0] VRP_DEP_Z  = 17'sd36510;

  // Clamp a signed value to the 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] res;
    if (v > 32'sd32767) begin
      res = 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

>>> hdl/vrp_pipe.sv
// Eleven-stage rotate and project datapath, one point per cycle.
module vrp_pipe
  import vrp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic signed [15:0] in_point_z,
  input  vrp_cfg_t           cfg,
  output logic               out_vld,
  output logic signed [15:0] out_pixel_x,
  output logic signed [15:0] out_pixel_y,
  output logic signed [15:0] out_view_depth
);

  localparam int unsigned LoW = 21;

  // valid bit per stage
  logic [VRP_LATENCY-1:0] vld_r;

  // stage 1: q times v
  logic signed [31:0] p_r [6];
  logic signed [31:0] p_nxt [6];
  logic signed [15:0] v1_r [3];
  // stage 2: t = 2 (q x v)
  logic signed [33:0] t_r [3];
  logic signed [33:0] t_nxt [3];
  logic signed [15:0] v2_r [3];
  // stage 3: q times t
  logic signed [49:0] m_r [9];
  logic signed [49:0] m_nxt [9];
  logic signed [15:0] v3_r [3];
  // stage 4: rotated point at 2^40
  logic signed [51:0] rs_r [3];
  logic signed [51:0] rs_nxt [3];
  // stage 5: rotated point at 2^12
  logic signed [23:0] r_r [3];
  logic signed [23:0] r_nxt [3];
  // stage 6: camera products
  logic signed [40:0] c_r [8];
  logic signed [40:0] c_nxt [8];
  // stage 7: camera sums
  logic signed [42:0] sx_r, sy_r, dp_r;
  logic signed [42:0] sx_nxt, sy_nxt, dp_nxt;
  // stage 8: scale partial products and depth
  logic signed [38:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic signed [38:0] xlo_nxt, xhi_nxt, ylo_nxt, yhi_nxt;
  logic signed [15:0] dz8_r, dz8_nxt;
  // stage 9: full scaled products
  logic signed [59:0] fx_r, fy_r, fx_nxt, fy_nxt;
  logic signed [15:0] dz9_r;
  // stage 10: truncated screen offsets
  logic signed [23:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic signed [15:0] dz10_r;
  // stage 11: output word
  logic signed [15:0] px_r, py_r, px_nxt, py_nxt;
  logic signed [15:0] dz11_r;

  // temporaries for truncation toward zero
  logic signed [51:0] rs_bias [3];
  logic signed [42:0] dp_bias;
  logic signed [26:0] dz_q;
  logic signed [59:0] fx_bias, fy_bias;
  logic signed [16:0] scale_s;

  assign scale_s = $signed({1'b0, cfg.pixel_scale});

  // stages 1 to 3: cross products and rotation products
  always_comb begin
    p_nxt[0] = cfg.quat_y * in_point_z;
    p_nxt[1] = cfg.quat_z * in_point_y;
    p_nxt[2] = cfg.quat_z * in_point_x;
    p_nxt[3] = cfg.quat_x * in_point_z;
    p_nxt[4] = cfg.quat_x * in_point_y;
    p_nxt[5] = cfg.quat_y * in_point_x;
    for (int i = 0; i < 3; i++) begin
      t_nxt[i] = (34'(p_r[2*i]) - 34'(p_r[2*i+1])) <<< 1;
    end
    m_nxt[0] = cfg.quat_w * t_r[0];
    m_nxt[1] = cfg.quat_y * t_r[2];
    m_nxt[2] = cfg.quat_z * t_r[1];
    m_nxt[3] = cfg.quat_w * t_r[1];
    m_nxt[4] = cfg.quat_z * t_r[0];
    m_nxt[5] = cfg.quat_x * t_r[2];
    m_nxt[6] = cfg.quat_w * t_r[2];
    m_nxt[7] = cfg.quat_x * t_r[1];
    m_nxt[8] = cfg.quat_y * t_r[0];
  end

  // stages 4 and 5: sum rotation terms, drop to Q.12 toward zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs_nxt[i] = (52'(v3_r[i]) <<< 28) + 52'(m_r[3*i]) + 52'(m_r[3*i+1])
                  - 52'(m_r[3*i+2]);
      rs_bias[i] = rs_r[i] + (rs_r[i][51] ? 52'sd268435455 : 52'sd0);
      r_nxt[i]   = 24'(rs_bias[i] >>> 28);
    end
  end

  // stages 6 and 7: camera rows
  always_comb begin
    c_nxt[0] = VRP_SCR_XX * r_r[0];
    c_nxt[1] = VRP_SCR_XY * r_r[1];
    c_nxt[2] = VRP_SCR_YX * r_r[0];
    c_nxt[3] = VRP_SCR_YY * r_r[1];
    c_nxt[4] = VRP_SCR_YZ * r_r[2];
    c_nxt[5] = VRP_DEP_X  * r_r[0];
    c_nxt[6] = VRP_DEP_Y  * r_r[1];
    c_nxt[7] = VRP_DEP_Z  * r_r[2];
    sx_nxt = 43'(c_r[0]) + 43'(c_r[1]);
    sy_nxt = 43'(c_r[2]) - 43'(c_r[3]) - 43'(c_r[4]);
    dp_nxt = 43'(c_r[5]) - 43'(c_r[6]) + 43'(c_r[7]);
  end

  // stage 8: split scale multiply, finish depth
  always_comb begin
    xlo_nxt = $signed({1'b0, sx_r[LoW-1:0]}) * scale_s;
    xhi_nxt = $signed(sx_r[42:LoW]) * scale_s;
    ylo_nxt = $signed({1'b0, sy_r[LoW-1:0]}) * scale_s;
    yhi_nxt = $signed(sy_r[42:LoW]) * scale_s;
    dp_bias = dp_r + (dp_r[42] ? 43'sd65535 : 43'sd0);
    dz_q    = 27'(dp_bias >>> 16);
    dz8_nxt = sat16(32'(dz_q));
  end

  // stages 9 to 11: combine, truncate, add center, clamp
  always_comb begin
    fx_nxt  = (60'(xhi_r) <<< LoW) + 60'(xlo_r);
    fy_nxt  = (60'(yhi_r) <<< LoW) + 60'(ylo_r);
    fx_bias = fx_r + (fx_r[59] ? 60'sh0_0000_000F_FFFF_FFFF : 60'sd0);
    fy_bias = fy_r + (fy_r[59] ? 60'sh0_0000_000F_FFFF_FFFF : 60'sd0);
    ox_nxt  = 24'(fx_bias >>> 36);
    oy_nxt  = 24'(fy_bias >>> 36);
    px_nxt  = sat16(32'(ox_r) + 32'(cfg.origin_x));
    py_nxt  = sat16(32'(oy_r) + 32'(cfg.origin_y));
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[VRP_LATENCY-2:0], in_vld};
    end
  end

  // advance payload every cycle
  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    v1_r   <= '{in_point_x, in_point_y, in_point_z};
    t_r    <= t_nxt;
    v2_r   <= v1_r;
    m_r    <= m_nxt;
    v3_r   <= v2_r;
    rs_r   <= rs_nxt;
    r_r    <= r_nxt;
    c_r    <= c_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    dp_r   <= dp_nxt;
    xlo_r  <= xlo_nxt;
    xhi_r  <= xhi_nxt;
    ylo_r  <= ylo_nxt;
    yhi_r  <= yhi_nxt;
    dz8_r  <= dz8_nxt;
    fx_r   <= fx_nxt;
    fy_r   <= fy_nxt;
    dz9_r  <= dz8_r;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    dz10_r <= dz9_r;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    dz11_r <= dz10_r;
  end

  assign out_vld        = vld_r[VRP_LATENCY-1];
  assign out_pixel_x    = px_r;
  assign out_pixel_y    = py_r;
  assign out_view_depth = dz11_r;

endmodule

>>> hdl/vertex_rotate_project.sv
// Top level: register port and the rotate/project pipeline.
//
// Rotates each body-frame point by the configured quaternion and projects it
// onto the screen through a fixed oblique camera. A point is taken in every
// cycle that start is high; busy never rises. Each result appears on the out_
// ports, marked by out_valid for one cycle, in the order taken; the receiver
// must take it then. The datapath pipeline has eleven register stages, the
// first loaded by the taking edge, made of two multiplier levels for the
// rotation, one for the camera rows and one split multiply for the pixel
// scale, each followed by adder stages, with truncation stages after the
// rotation sum and the scaled products. Write registers only while no point
// is in flight.
module vertex_rotate_project
  import vrp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  start,
  output logic                  busy,
  input  logic signed [15:0]    in_point_x,
  input  logic signed [15:0]    in_point_y,
  input  logic signed [15:0]    in_point_z,
  // result channel
  output logic                  out_valid,
  output logic signed [15:0]    out_pixel_x,
  output logic signed [15:0]    out_pixel_y,
  output logic signed [15:0]    out_view_depth,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [VRP_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  vrp_cfg_t cfg_r, cfg_nxt;
  logic     wr_en;
  vrp_reg_t reg_sel;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = vrp_reg_t'(paddr[VRP_ADDR_W-1:2]);

  // decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_QUAT_W:      cfg_nxt.quat_w      = pwdata[15:0];
        REG_QUAT_X:      cfg_nxt.quat_x      = pwdata[15:0];
        REG_QUAT_Y:      cfg_nxt.quat_y      = pwdata[15:0];
        REG_QUAT_Z:      cfg_nxt.quat_z      = pwdata[15:0];
        REG_ORIGIN_X:    cfg_nxt.origin_x    = pwdata[15:0];
        REG_ORIGIN_Y:    cfg_nxt.origin_y    = pwdata[15:0];
        REG_PIXEL_SCALE: cfg_nxt.pixel_scale = pwdata[15:0];
        default: ;
      endcase
    end
  end

  // hold register values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quat_w      <= VRP_QUAT_W_RST;
      cfg_r.quat_x      <= '0;
      cfg_r.quat_y      <= '0;
      cfg_r.quat_z      <= '0;
      cfg_r.origin_x    <= '0;
      cfg_r.origin_y    <= '0;
      cfg_r.pixel_scale <= VRP_SCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_QUAT_W:      prdata[15:0] = cfg_r.quat_w;
      REG_QUAT_X:      prdata[15:0] = cfg_r.quat_x;
      REG_QUAT_Y:      prdata[15:0] = cfg_r.quat_y;
      REG_QUAT_Z:      prdata[15:0] = cfg_r.quat_z;
      REG_ORIGIN_X:    prdata[15:0] = cfg_r.origin_x;
      REG_ORIGIN_Y:    prdata[15:0] = cfg_r.origin_y;
      REG_PIXEL_SCALE: prdata[15:0] = cfg_r.pixel_scale;
      default: ;
    endcase
  end

  vrp_pipe u_pipe (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vld         (start && !busy),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .cfg            (cfg_r),
    .out_vld        (out_valid),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_view_depth (out_view_depth)
  );

endmodule

>>> hdl/vrp_checker.sv
// Port-level checker for the vertex rotate/project block, bound to the top.
`include "vertex_rotate_project_assert.svh"

module vrp_checker
  import vrp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [VRP_ADDR_W-1:0] paddr,
  input logic [31:0]           pwdata,
  input logic [31:0]           prdata,
  input logic                  pready
);

  logic [VRP_LATENCY-1:0] acc_hist_r;
  logic [VRP_ADDR_W-1:0]  wr_addr_r;
  logic [15:0]            wr_data_r;
  logic                   reg_wr;
  logic                   rd_same;

  // track accepted words to line them up with results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_hist_r <= '0;
    end else begin
      acc_hist_r <= {acc_hist_r[VRP_LATENCY-2:0], start && !busy};
    end
  end

  // hold last cycle's address and data for the readback check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_addr_r <= '0;
      wr_data_r <= '0;
    end else begin
      wr_addr_r <= paddr;
      wr_data_r <= pwdata[15:0];
    end
  end

  assign reg_wr  = psel && penable && pwrite && pready
                   && (paddr[VRP_ADDR_W-1:2] <= REG_PIXEL_SCALE);
  assign rd_same = psel && !pwrite && (paddr == wr_addr_r);

  // one result per accepted word, at fixed latency
  `VRP_CHECK(a_result_latency, out_valid == acc_hist_r[VRP_LATENCY-1])

  // the block never refuses a word
  `VRP_CHECK(a_never_busy, !busy)

  // a written register reads back its value on the next cycle
  `VRP_IMPLY(a_write_readback, reg_wr, !rd_same || prdata[15:0] == wr_data_r)

  // no results before any word has gone in after reset
  `VRP_IMPLY(a_idle_quiet, acc_hist_r == '0 && !(start && !busy), !out_valid)

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for vertex_rotate_project: directed and random points checked against a predictor.
module testbench;
  import vrp_pkg::*;

  localparam int unsigned NUM_REGS        = 7;
  localparam int unsigned REG_SPARE       = 7;   // first index past the register map
  localparam int unsigned RESULT_DELAY    = 11;
  localparam int unsigned SETTLE_CYCLES   = RESULT_DELAY + 5;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned WORDS_PER_PHASE = 103;
  localparam int unsigned MAX_PRINTED     = 40;

  // Camera rows, round(c * 65536)
  localparam longint ROW_XX  = 58615;
  localparam longint ROW_XY  = 29308;
  localparam longint ROW_YX  = 16325;
  localparam longint ROW_YY  = 32657;
  localparam longint ROW_YZ  = 54428;
  localparam longint DEPTH_X = 24340;
  localparam longint DEPTH_Y = 48680;
  localparam longint DEPTH_Z = 36510;
  localparam longint ONE_Q28 = 64'sd1 << 28;
  localparam longint ONE_Q36 = 64'sd1 << 36;
  localparam longint ONE_Q16 = 64'sd1 << 16;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] depth;
  } screen_word_t;

  typedef logic [15:0] reg_file_t [NUM_REGS];

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic signed [15:0]    in_point_x = '0;
  logic signed [15:0]    in_point_y = '0;
  logic signed [15:0]    in_point_z = '0;
  logic                  out_valid;
  logic signed [15:0]    out_pixel_x;
  logic signed [15:0]    out_pixel_y;
  logic signed [15:0]    out_view_depth;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [VRP_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  reg_file_t    regs_now;
  screen_word_t expected_pixels[$];
  int unsigned  mismatch_count = 0;

  vertex_rotate_project DUT (.*);

  always #5 clk = ~clk;

  // Run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Print one line per mismatch, quietly past the cap, and count
  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    end
    mismatch_count++;
  endtask

  function automatic logic signed [15:0] clamp_word(longint v);
    logic signed [15:0] res;
    if (v > 32767) begin
      res = 16'sh7FFF;
    end else if (v < -32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  // Rotate by q with t = 2(q x v), then project through the fixed camera
  function automatic screen_word_t project_vertex(vertex_t v, reg_file_t r);
    longint vx, vy, vz, qw, qx, qy, qz;
    longint tx, ty, tz, rx, ry, rz;
    longint sx, sy, dp, scale, cx, cy;
    screen_word_t w;
    vx = $signed(v.x);
    vy = $signed(v.y);
    vz = $signed(v.z);
    qw = $signed(r[REG_QUAT_W]);
    qx = $signed(r[REG_QUAT_X]);
    qy = $signed(r[REG_QUAT_Y]);
    qz = $signed(r[REG_QUAT_Z]);
    cx = $signed(r[REG_ORIGIN_X]);
    cy = $signed(r[REG_ORIGIN_Y]);
    scale = r[REG_PIXEL_SCALE];
    tx = 2 * (qy * vz - qz * vy);
    ty = 2 * (qz * vx - qx * vz);
    tz = 2 * (qx * vy - qy * vx);
    // back to Q.12, truncating toward zero, no saturation
    rx = (vx * ONE_Q28 + qw * tx + qy * tz - qz * ty) / ONE_Q28;
    ry = (vy * ONE_Q28 + qw * ty + qz * tx - qx * tz) / ONE_Q28;
    rz = (vz * ONE_Q28 + qw * tz + qx * ty - qy * tx) / ONE_Q28;
    sx = ROW_XX * rx + ROW_XY * ry;
    sy = ROW_YX * rx - ROW_YY * ry - ROW_YZ * rz;
    dp = DEPTH_X * rx - DEPTH_Y * ry + DEPTH_Z * rz;
    w.px    = clamp_word(cx + (sx * scale) / ONE_Q36);
    w.py    = clamp_word(cy + (sy * scale) / ONE_Q36);
    w.depth = clamp_word(dp / ONE_Q16);
    return w;
  endfunction

  // Check each result word, then log the word accepted at this edge
  always @(posedge clk) begin : track_words
    screen_word_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_pixel_x, out_pixel_y, out_view_depth};
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with none pending, pixel_x", got.px, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (got.px !== want.px) report_mismatch("pixel_x", got.px, want.px);
        if (got.py !== want.py) report_mismatch("pixel_y", got.py, want.py);
        if (got.depth !== want.depth) report_mismatch("view_depth", got.depth, want.depth);
      end
    end
    if (rst_n && start && !busy) begin
      expected_pixels.push_back(
        project_vertex('{in_point_x, in_point_y, in_point_z}, regs_now));
    end
  end

  // Hold reset, preload the register image with reset values
  task automatic reset_block();
    regs_now[REG_QUAT_W]      = VRP_QUAT_W_RST;
    regs_now[REG_QUAT_X]      = '0;
    regs_now[REG_QUAT_Y]      = '0;
    regs_now[REG_QUAT_Z]      = '0;
    regs_now[REG_ORIGIN_X]    = '0;
    regs_now[REG_ORIGIN_Y]    = '0;
    regs_now[REG_PIXEL_SCALE] = VRP_SCALE_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Setup and access phase of a register write; upper data bits are don't-care
  task automatic cfg_write(int unsigned index, logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VRP_ADDR_W'(index * 4);
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (index < NUM_REGS) regs_now[index] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read(int unsigned index, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= VRP_ADDR_W'(index * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Read back every register against the image
  task automatic check_registers();
    logic [31:0] data;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_read(i, data);
      if (data[15:0] !== regs_now[i]) begin
        report_mismatch("register readback", data[15:0], regs_now[i]);
      end
    end
  endtask

  // Drop start and hold until every pending word has come out
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic load_registers(reg_file_t vals);
    wait_drained();
    for (int i = 0; i < NUM_REGS; i++) cfg_write(i, vals[i]);
    check_registers();
  endtask

  // Present one word until taken, then idle for the given gap
  task automatic send_point(vertex_t v, int unsigned gap);
    start      <= 1'b1;
    in_point_x <= v.x;
    in_point_y <= v.y;
    in_point_z <= v.z;
    do @(posedge clk); while (busy !== 1'b0);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_extreme();
    logic [15:0] v;
    case ($urandom_range(0, 4))
      0: v = 16'h8000;
      1: v = 16'hC000;
      2: v = 16'h0000;
      3: v = 16'h4000;
      default: v = 16'h7FFF;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] random_coord();
    int unsigned pick;
    logic signed [15:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      c = pick_extreme();
    end else if (pick < 40) begin
      c = 16'($urandom_range(0, 16383) - 8192);
    end else begin
      c = 16'($urandom);
    end
    return c;
  endfunction

  function automatic vertex_t random_vertex();
    vertex_t v;
    v.x = random_coord();
    v.y = random_coord();
    v.z = random_coord();
    return v;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned random_gap();
    int unsigned pick;
    int unsigned gap;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      gap = 0;
    end else if (pick < 85) begin
      gap = $urandom_range(1, 3);
    end else if (pick < 97) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(20, 60);
    end
    return gap;
  endfunction

  // Unit quaternions half of the time, raw or extreme ones otherwise
  task automatic random_setup(output reg_file_t r);
    real a, b, c, d, n;
    int unsigned kind;
    kind = $urandom_range(0, 3);
    if (kind < 2) begin
      a = real'($urandom_range(0, 2000)) - 1000.0;
      b = real'($urandom_range(0, 2000)) - 1000.0;
      c = real'($urandom_range(0, 2000)) - 1000.0;
      d = real'($urandom_range(0, 2000)) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin
        a = 1.0;
        n = 1.0;
      end
      r[REG_QUAT_W] = 16'($rtoi(a / n * 16384.0));
      r[REG_QUAT_X] = 16'($rtoi(b / n * 16384.0));
      r[REG_QUAT_Y] = 16'($rtoi(c / n * 16384.0));
      r[REG_QUAT_Z] = 16'($rtoi(d / n * 16384.0));
    end else if (kind == 2) begin
      r[REG_QUAT_W] = 16'($urandom);
      r[REG_QUAT_X] = 16'($urandom);
      r[REG_QUAT_Y] = 16'($urandom);
      r[REG_QUAT_Z] = 16'($urandom);
    end else begin
      r[REG_QUAT_W] = pick_extreme();
      r[REG_QUAT_X] = pick_extreme();
      r[REG_QUAT_Y] = pick_extreme();
      r[REG_QUAT_Z] = pick_extreme();
    end
    r[REG_ORIGIN_X] = ($urandom_range(0, 3) == 0) ?
                      16'($urandom) : 16'($urandom_range(0, 1023) - 512);
    r[REG_ORIGIN_Y] = ($urandom_range(0, 3) == 0) ?
                      16'($urandom) : 16'($urandom_range(0, 1023) - 512);
    case ($urandom_range(0, 3))
      0: r[REG_PIXEL_SCALE] = VRP_SCALE_RST;
      1: r[REG_PIXEL_SCALE] = 16'($urandom_range(1, 4096));
      2: r[REG_PIXEL_SCALE] = 16'($urandom);
      default: r[REG_PIXEL_SCALE] = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
    endcase
  endtask

  task automatic test_reset_values();
    check_registers();
  endtask

  // Identity rotation at unit scale: axes, origin and field extremes
  task automatic test_identity_points();
    send_point('{16'sd0, 16'sd0, 16'sd0}, 0);
    send_point('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 0);
    send_point('{16'sh8000, 16'sh8000, 16'sh8000}, 1);
    send_point('{16'sd4096, 16'sd0, 16'sd0}, 0);
    send_point('{16'sd0, 16'sd4096, 16'sd0}, 2);
    send_point('{16'sd0, 16'sd0, 16'sd4096}, 0);
    wait_drained();
  endtask

  // Full scale with centers at the edges: push pixels past both limits
  task automatic test_saturation();
    cfg_write(REG_PIXEL_SCALE, 16'hFFFF);
    cfg_write(REG_ORIGIN_X, 16'h7FFF);
    cfg_write(REG_ORIGIN_Y, 16'h8000);
    check_registers();
    send_point('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 0);
    send_point('{16'sh8000, 16'sh8000, 16'sh8000}, 0);
    send_point('{16'sd0, 16'sd0, 16'sd0}, 0);
    wait_drained();
    cfg_write(REG_ORIGIN_X, 16'h8000);
    cfg_write(REG_ORIGIN_Y, 16'h7FFF);
    send_point('{16'sh8000, 16'sh7FFF, 16'sh8000}, 0);
    send_point('{16'sh7FFF, 16'sh8000, 16'sh7FFF}, 0);
    send_point('{16'sd1, -16'sd1, 16'sd1}, 0);
    wait_drained();
  endtask

  // Quaternion used as given: two's-complement extremes, no normalization
  task automatic test_non_unit_quaternion();
    cfg_write(REG_QUAT_W, 16'h8000);
    cfg_write(REG_QUAT_X, 16'h8000);
    cfg_write(REG_QUAT_Y, 16'h8000);
    cfg_write(REG_QUAT_Z, 16'h8000);
    cfg_write(REG_PIXEL_SCALE, 16'h0001);
    cfg_write(REG_ORIGIN_X, 16'h0000);
    cfg_write(REG_ORIGIN_Y, 16'h0000);
    check_registers();
    send_point('{16'sh7FFF, 16'sh8000, 16'sh7FFF}, 0);
    send_point('{16'sh8000, 16'sh7FFF, 16'sh0000}, 0);
    send_point('{16'sd4096, 16'sd4096, -16'sd4096}, 0);
    wait_drained();
    cfg_write(REG_QUAT_W, 16'h7FFF);
    cfg_write(REG_QUAT_X, 16'h7FFF);
    cfg_write(REG_QUAT_Y, 16'h0000);
    cfg_write(REG_QUAT_Z, 16'h7FFF);
    send_point('{16'sh7FFF, 16'sh7FFF, 16'sh8000}, 0);
    send_point('{-16'sd1, 16'sd2, -16'sd3}, 0);
    wait_drained();
    cfg_write(REG_PIXEL_SCALE, 16'h0000);
    send_point('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 0);
    wait_drained();
  endtask

  // Write past the register map: must leave every register alone
  task automatic test_spare_register();
    cfg_write(REG_SPARE, 16'($urandom));
    check_registers();
    send_point('{16'sh1234, -16'sh0777, 16'sh4000}, 0);
    send_point('{16'sh8000, 16'sh0001, 16'sh7FFF}, 0);
    wait_drained();
  endtask

  // Random setups, each followed by a stream of random words
  task automatic test_random_phases();
    reg_file_t setup;
    bit streaming;
    streaming = 1'b0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_setup(setup);
      load_registers(setup);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n % 16 == 0) streaming = ($urandom_range(0, 2) == 0);
        // pause the sender until the pipe is empty now and then
        if ((phase == 0 && n == WORDS_PER_PHASE / 2) || $urandom_range(0, 199) == 0) begin
          wait_drained();
        end
        send_point(random_vertex(), streaming ? 0 : random_gap());
      end
    end
  endtask

  initial begin
    reset_block();
    test_reset_values();
    test_identity_points();
    test_saturation();
    test_non_unit_quaternion();
    test_spare_register();
    test_random_phases();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      report_mismatch("words never returned", expected_pixels.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/vrp_pkg.sv
hdl/vrp_pipe.sv
hdl/vertex_rotate_project.sv
hdl/vrp_checker.sv
dv/testbench.sv
